>>> rtl/core/ccse_pkg.sv
// Shared constants and types of the cluster chain to sector extent converter.
package ccse_pkg;

  // Bytes in one sector and the matching shift for the sector count.
  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  localparam int unsigned CLUSTER_W = 28;
  localparam int unsigned SECTOR_W  = 32;
  localparam int unsigned LENGTH_W  = 24;
  localparam int unsigned SPC_W     = 8;
  localparam int unsigned SIZE_W    = 32;

  // Lowest cluster number that maps to the data area.
  localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = CLUSTER_W'(2);

  // Configuration register indexes.
  localparam logic [1:0] REG_SECTORS_PER_CLUSTER = 2'd0;
  localparam logic [1:0] REG_DATA_BASE_SECTOR    = 2'd1;
  localparam logic [1:0] REG_FAT_ENTRY_COUNT     = 2'd2;
  localparam logic [1:0] REG_FILE_SIZE_BYTES     = 2'd3;

  // Result queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [SECTOR_W-1:0] run_start;
    logic [LENGTH_W-1:0] run_length;
    logic                final_run;
    logic                bad_cluster;
  } result_t;

endpackage

>>> rtl/core/cluster_chain_sector_extents.sv
// Top level of the cluster chain to sector extent converter.
//
// The block takes one cluster number per cycle and one request at a time: the
// first request of a file carries the file's first cluster, and the file size
// held in the configuration registers is turned into a sector count at that
// point. Each cluster is range checked against 2 .. fat_entry_count-1 in the
// first stage, where its first data sector is also formed by one narrow
// multiply and an add. The second stage merges the sectors with the open run,
// trimmed to what the file still needs, and pushes zero, one or two results
// into a four-entry result queue; a request that closes a run on a gap and also
// ends the file yields two. The sustained rate is one cluster per cycle for as
// long as the downstream side takes one result per cycle; the second stage only
// advances while the queue has room for two results, so the input stalls when
// the queue already holds three or four. An accepted request is registered in
// stage 1 before its results enter the queue. An empty file gives one final
// result of length zero; an invalid cluster gives one final result with
// bad_cluster set and drops the open run. Configuration must only be written
// while the block is idle; writes are always taken at once.
module cluster_chain_sector_extents (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [27:0] in_cluster,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_run_start,
  output logic [23:0] out_run_length,
  output logic        out_final_run,
  output logic        out_bad_cluster,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic [ccse_pkg::SPC_W-1:0]     spc_r;
  logic [ccse_pkg::SECTOR_W-1:0]  data_base_r;
  logic [ccse_pkg::CLUSTER_W-1:0] fat_count_r;
  logic [ccse_pkg::SIZE_W-1:0]    file_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r       <= ccse_pkg::SPC_W'(1);
      data_base_r <= '0;
      fat_count_r <= '0;
      file_size_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccse_pkg::REG_SECTORS_PER_CLUSTER: spc_r <= cfg_data[ccse_pkg::SPC_W-1:0];
        ccse_pkg::REG_DATA_BASE_SECTOR:    data_base_r <= cfg_data;
        ccse_pkg::REG_FAT_ENTRY_COUNT:     fat_count_r <= cfg_data[ccse_pkg::CLUSTER_W-1:0];
        ccse_pkg::REG_FILE_SIZE_BYTES:     file_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A sectors-per-cluster value of zero behaves as one.
  logic [ccse_pkg::SPC_W-1:0] spc_eff;
  assign spc_eff = (spc_r == '0) ? ccse_pkg::SPC_W'(1) : spc_r;

  // ---------------------------------------------------------------------------
  // Stage 1: range check and cluster to sector mapping.
  // ---------------------------------------------------------------------------
  logic                           s1_valid_r;
  logic                           s1_bad_r;
  logic [ccse_pkg::SECTOR_W-1:0]  s1_sect_r;
  logic                           s2_fire;

  logic [ccse_pkg::CLUSTER_W-1:0] clst_offset;
  logic [ccse_pkg::CLUSTER_W+ccse_pkg::SPC_W-1:0] clst_product;
  logic [ccse_pkg::SECTOR_W-1:0]  sect_nxt;
  logic                           bad_nxt;

  assign in_ready     = !s1_valid_r || s2_fire;
  assign clst_offset  = in_cluster - ccse_pkg::FIRST_DATA_CLUSTER;
  assign clst_product = clst_offset * spc_eff;
  assign sect_nxt     = clst_product[ccse_pkg::SECTOR_W-1:0] + data_base_r;
  assign bad_nxt      = (in_cluster < ccse_pkg::FIRST_DATA_CLUSTER) ||
                        (in_cluster >= fat_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sect_r <= sect_nxt;
      s1_bad_r  <= bad_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: run merging and file bookkeeping.
  // ---------------------------------------------------------------------------
  logic                          run_open_r;
  logic [ccse_pkg::SECTOR_W-1:0] run_start_r;
  logic [ccse_pkg::LENGTH_W-1:0] run_len_r;
  logic [ccse_pkg::LENGTH_W-1:0] sectors_left_r;

  logic                          run_open_nxt;
  logic [ccse_pkg::SECTOR_W-1:0] run_start_nxt;
  logic [ccse_pkg::LENGTH_W-1:0] run_len_nxt;
  logic [ccse_pkg::LENGTH_W-1:0] sectors_left_nxt;

  logic [ccse_pkg::SIZE_W:0]     size_round;
  logic [ccse_pkg::LENGTH_W-1:0] need_sectors;
  logic [ccse_pkg::LENGTH_W-1:0] left_now;
  logic [ccse_pkg::LENGTH_W-1:0] spc_wide;
  logic [ccse_pkg::LENGTH_W-1:0] take;
  logic [ccse_pkg::SECTOR_W-1:0] run_end;
  logic                          extend;

  ccse_pkg::result_t res_a;
  ccse_pkg::result_t res_b;
  logic [1:0]        res_count;
  logic              push_final;

  // Sectors needed by the file, rounded up.
  assign size_round   = {1'b0, file_size_r} +
                        (ccse_pkg::SIZE_W + 1)'(ccse_pkg::SECTOR_BYTES - 1);
  assign need_sectors = ccse_pkg::LENGTH_W'(size_round >> ccse_pkg::SECTOR_SHIFT);
  assign left_now     = run_open_r ? sectors_left_r : need_sectors;
  assign spc_wide     = ccse_pkg::LENGTH_W'(spc_eff);
  assign take         = (spc_wide < left_now) ? spc_wide : left_now;
  assign run_end      = run_start_r + ccse_pkg::SECTOR_W'(run_len_r);
  assign extend       = run_open_r && (s1_sect_r == run_end);

  always_comb begin
    run_open_nxt     = run_open_r;
    run_start_nxt    = run_start_r;
    run_len_nxt      = run_len_r;
    sectors_left_nxt = sectors_left_r;
    res_a            = '0;
    res_b            = '0;
    res_count        = 2'd0;

    if (!run_open_r && (need_sectors == '0)) begin
      // Empty file: one final result of length zero, cluster ignored.
      res_a.final_run = 1'b1;
      res_count       = 2'd1;
      sectors_left_nxt = '0;
    end else if (s1_bad_r) begin
      // Invalid cluster: report it and drop whatever run was open.
      res_a.final_run   = 1'b1;
      res_a.bad_cluster = 1'b1;
      res_count         = 2'd1;
      run_open_nxt      = 1'b0;
      run_start_nxt     = '0;
      run_len_nxt       = '0;
      sectors_left_nxt  = '0;
    end else begin
      if (extend) begin
        run_len_nxt = run_len_r + take;
      end else begin
        if (run_open_r) begin
          res_a.run_start  = run_start_r;
          res_a.run_length = run_len_r;
          res_count        = 2'd1;
        end
        run_start_nxt = s1_sect_r;
        run_len_nxt   = take;
        run_open_nxt  = 1'b1;
      end
      sectors_left_nxt = left_now - take;
      if (sectors_left_nxt == '0) begin
        // The file is covered: emit the run that ends it.
        if (res_count == 2'd0) begin
          res_a.run_start  = run_start_nxt;
          res_a.run_length = run_len_nxt;
          res_a.final_run  = 1'b1;
        end else begin
          res_b.run_start  = run_start_nxt;
          res_b.run_length = run_len_nxt;
          res_b.final_run  = 1'b1;
        end
        res_count    = res_count + 2'd1;
        run_open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r     <= 1'b0;
      run_start_r    <= '0;
      run_len_r      <= '0;
      sectors_left_r <= '0;
    end else if (s2_fire) begin
      run_open_r     <= run_open_nxt;
      run_start_r    <= run_start_nxt;
      run_len_r      <= run_len_nxt;
      sectors_left_r <= sectors_left_nxt;
    end
  end

  assign push_final = (res_count != 2'd0);

  // ---------------------------------------------------------------------------
  // Result queue.
  // ---------------------------------------------------------------------------
  ccse_pkg::result_t                   queue_r [ccse_pkg::QUEUE_DEPTH];
  logic [ccse_pkg::QPTR_W-1:0]         wr_ptr_r;
  logic [ccse_pkg::QPTR_W-1:0]         rd_ptr_r;
  logic [ccse_pkg::QPTR_W:0]           count_r;
  logic [ccse_pkg::QPTR_W:0]           count_nxt;
  logic [ccse_pkg::QPTR_W-1:0]         wr_ptr_inc;
  logic                                pop;
  logic [ccse_pkg::QPTR_W:0]           push_n;

  // Stage 2 only advances when two results would still fit.
  assign s2_fire    = s1_valid_r &&
                      (count_r <= (ccse_pkg::QPTR_W + 1)'(ccse_pkg::QUEUE_DEPTH - 2));
  assign pop        = out_valid && out_ready;
  assign push_n     = s2_fire ? (ccse_pkg::QPTR_W + 1)'(res_count) : '0;
  assign wr_ptr_inc = wr_ptr_r + ccse_pkg::QPTR_W'(1);
  assign count_nxt  = count_r + push_n - (ccse_pkg::QPTR_W + 1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ccse_pkg::QPTR_W'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ccse_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && (res_count != 2'd0)) begin
      queue_r[wr_ptr_r] <= res_a;
    end
    if (s2_fire && (res_count == 2'd2)) begin
      queue_r[wr_ptr_inc] <= res_b;
    end
  end

  ccse_pkg::result_t head;
  assign head            = queue_r[rd_ptr_r];
  assign out_valid       = (count_r != '0);
  assign out_run_start   = head.run_start;
  assign out_run_length  = head.run_length;
  assign out_final_run   = head.final_run;
  assign out_bad_cluster = head.bad_cluster;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (ccse_pkg::QPTR_W + 1)'(ccse_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> s1_valid_r)
    else $error("stalled request lost from stage 1");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && push_final && !run_open_nxt) |=> !run_open_r)
    else $error("run left open after the file ended");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s1_bad_r) |-> (res_count == 2'd1))
    else $error("invalid cluster did not give exactly one result");

endmodule
